// ===== rtl/core/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg: shared types and constants for the RC4 random generator
// Holds field widths, register map, input kinds and the request struct.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int KeyBytes   = 128;
  localparam int KeyIdxW    = $clog2(KeyBytes);
  localparam int KeyLenW    = $clog2(KeyBytes + 1);

  localparam logic [23:0] BudgetReset  = 24'd1600000;
  localparam logic [11:0] DiscardReset = 12'd1024;

  localparam logic [31:0] BudgetFloor  = 32'h8000_0000;

  typedef enum logic [1:0] {
    KIND_ENTROPY = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_WORD    = 2'd2,
    KIND_UNIFORM = 2'd3
  } kind_t;

  localparam logic [0:0] REG_BUDGET  = 1'b0;
  localparam logic [0:0] REG_DISCARD = 1'b1;

  // Request from the sequencer to the modulo unit, and its status back.
  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] rem;
  } mod_rsp_t;

endpackage

// ===== rtl/core/rc4_if.sv =====
// ----------------------------------------------------------------------------
// rc4_in_if / rc4_out_if: valid-ready channels of the RC4 random generator
// Input channel carries a request beat; output channel a result beat.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  entropy_byte;
  logic        entropy_last;
  logic [31:0] draw_limit;

  modport source (output valid, kind, entropy_byte, entropy_last, draw_limit,
                  input ready);
  modport sink   (input valid, kind, entropy_byte, entropy_last, draw_limit,
                  output ready);
endinterface

interface rc4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        reseed_due;

  modport source (output valid, value, reseed_due, input ready);
  modport sink   (input valid, value, reseed_due, output ready);
endinterface

// ===== rtl/core/rc4_random_generator.sv =====
// ----------------------------------------------------------------------------
// rc4_random_generator: RC4 keystream generator with stir and reseed budget
// Steps: a byte draw is one RC4 step, a word four; a uniform draw does a modulo
// pass (2^32 mod limit), draws words until one is not below it and reduces
// it in a second pass. A stir does 256 key-mixing swaps, then the discard.
// Throughput: one item at a time; set by the single permutation RAM port and
// the serial modulo unit; no beat is taken while a result beat waits.
// Reset: a pass loads the identity permutation; no item is taken meanwhile.
// Configuration writes are taken at all times.
// ----------------------------------------------------------------------------
module rc4_random_generator
  import rc4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rc4_in_if.sink      in_ch,
  rc4_out_if.source   out_ch
);

  typedef enum logic [16:0] {
    S_INIT   = 17'b00000000000000001,
    S_IDLE   = 17'b00000000000000010,
    S_MOD0   = 17'b00000000000000100,  // wait for 2^32 mod bound
    S_RDA    = 17'b00000000000001000,  // read S[i]
    S_RDB    = 17'b00000000000010000,  // latch a, read S[j]
    S_SWP    = 17'b00000000000100000,  // latch b, write S[i]
    S_WRJ    = 17'b00000000001000000,  // write S[j]
    S_RDO    = 17'b00000000010000000,  // read S[a+b]
    S_OUT    = 17'b00000000100000000,  // latch byte
    S_MOD1   = 17'b00000001000000000,  // wait for word mod bound
    S_EMIT   = 17'b00000010000000000,
    S_KRDA   = 17'b00000100000000000,  // key mixing
    S_KRDB   = 17'b00001000000000000,
    S_KSWP   = 17'b00010000000000000,
    S_KWRJ   = 17'b00100000000000000,
    S_DISC   = 17'b01000000000000000,  // decide next discard
    S_SEED   = 17'b10000000000000000   // seed byte read
  } state_t;

  state_t state;

  // --- configuration --------------------------------------------------------
  logic [23:0] reseed_budget;
  logic [11:0] discard_count;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      reseed_budget <= BudgetReset;
      discard_count <= DiscardReset;
    end else if (cfg_wr && paddr[2] == REG_DISCARD) begin
      discard_count <= pwdata[11:0];
    end else if (cfg_wr && paddr[2] == REG_BUDGET) begin
      reseed_budget <= pwdata[23:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BUDGET:  prdata = {8'd0, reseed_budget};
      REG_DISCARD: prdata = {20'd0, discard_count};
      default:     prdata = '0;
    endcase
  end

  // --- datapath registers ---------------------------------------------------
  logic [7:0]         idx_i, idx_j, ra, rb;
  logic [KeyLenW-1:0] seed_len;
  logic [KeyLenW-1:0] key_len;
  logic [KeyIdxW-1:0] key_pos;
  logic [8:0]         mix_cnt;
  logic [11:0]        disc_left;
  logic [31:0]        budget;      // signed
  logic [1:0]         kind;
  logic [1:0]         byte_cnt;
  logic [31:0]        word;
  logic [31:0]        bound;
  logic [31:0]        floor_v;
  logic               due;
  logic               discarding;
  logic               ov;
  logic [31:0]        oval;
  logic               odue;

  logic [7:0]  j_next;
  logic [32:0] spend;

  // --- permutation RAM, one port ---------------------------------------------
  logic [7:0] perm [256];
  logic [7:0] ram_addr;
  logic [7:0] ram_wdata;
  logic       ram_we;
  logic [7:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (ram_we) perm[ram_addr] <= ram_wdata;
    ram_rdata <= perm[ram_addr];
  end

  // --- seed buffer ----------------------------------------------------------
  logic [7:0]         seed [KeyBytes];
  logic [KeyIdxW-1:0] seed_raddr;
  logic [7:0]         seed_rdata;
  logic               seed_we;

  always_ff @(posedge clk) begin
    if (seed_we) seed[seed_len[KeyIdxW-1:0]] <= in_ch.entropy_byte;
    seed_rdata <= seed[seed_raddr];
  end

  mod_req_t mreq;
  mod_rsp_t mrsp;

  rc4_mod_unit u_mod (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  assign in_ch.ready = (state == S_IDLE) && !ov;
  assign out_ch.valid = ov;
  assign out_ch.value = oval;
  assign out_ch.reseed_due = odue;

  // signed subtract with floor at -2^31
  always_comb begin
    spend = {budget[31], budget} - ((kind == KIND_BYTE) ? 33'd1 : 33'd4);
  end

  // RAM address and write control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_i;
    ram_wdata = rb;
    j_next    = idx_j + ram_rdata;
    unique case (state)
      S_INIT: begin
        ram_we = 1'b1; ram_addr = mix_cnt[7:0]; ram_wdata = mix_cnt[7:0];
      end
      S_RDB:  ram_addr = j_next;
      S_KRDB: ram_addr = j_next + seed_rdata;
      S_SWP, S_KSWP: begin
        ram_we = 1'b1; ram_addr = idx_i; ram_wdata = ram_rdata;
      end
      S_WRJ, S_KWRJ: begin
        ram_we = 1'b1; ram_addr = idx_j; ram_wdata = ra;
      end
      S_RDO:  ram_addr = ra + rb;
      default: ram_addr = idx_i;
    endcase
  end

  always_comb begin
    mreq.start    = 1'b0;
    mreq.dividend = 33'h1_0000_0000;
    mreq.divisor  = bound;
    if (state == S_IDLE && in_ch.valid && !ov && in_ch.kind == KIND_UNIFORM
        && in_ch.draw_limit >= 32'd2) begin
      mreq.start   = 1'b1;
      mreq.divisor = in_ch.draw_limit;
    end else if (state == S_OUT && byte_cnt == 2'd3 && !discarding
                 && kind == KIND_UNIFORM && {word[23:0], ram_rdata} >= floor_v) begin
      mreq.start    = 1'b1;
      mreq.dividend = {1'b0, word[23:0], ram_rdata};
    end
  end

  assign seed_we = (state == S_IDLE) && in_ch.valid && !ov
                   && in_ch.kind == KIND_ENTROPY && seed_len < KeyLenW'(KeyBytes);
  assign seed_raddr = key_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      mix_cnt  <= '0;
      idx_i    <= '0;
      idx_j    <= '0;
      seed_len <= '0;
      budget   <= '0;
      ov       <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) ov <= 1'b0;
      unique case (state)
        S_INIT: begin
          mix_cnt <= mix_cnt + 9'd1;
          if (mix_cnt == 9'd255) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            kind       <= in_ch.kind;
            bound      <= in_ch.draw_limit;
            due        <= 1'b0;
            byte_cnt   <= 2'd0;
            discarding <= 1'b0;
            unique case (in_ch.kind)
              KIND_ENTROPY: begin
                if (seed_len < KeyLenW'(KeyBytes)) seed_len <= seed_len + 1'b1;
                if (in_ch.entropy_last) begin
                  key_len <= (seed_len < KeyLenW'(KeyBytes)) ?
                             seed_len + 1'b1 : seed_len;
                  key_pos <= '0;
                  mix_cnt <= '0;
                  state   <= S_SEED;
                end
              end
              KIND_BYTE: begin
                due   <= budget[31] || budget == 32'd0;
                idx_i <= idx_i + 8'd1;
                state <= S_RDA;
              end
              KIND_WORD: begin
                due   <= budget[31] || budget == 32'd0;
                idx_i <= idx_i + 8'd1;
                state <= S_RDA;
              end
              KIND_UNIFORM: begin
                if (in_ch.draw_limit < 32'd2) begin
                  ov <= 1'b1; oval <= '0; odue <= 1'b0;
                end else begin
                  state <= S_MOD0;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MOD0: begin
          if (mrsp.done) begin
            floor_v <= mrsp.rem;
            due     <= due || budget[31] || budget == 32'd0;
            idx_i   <= idx_i + 8'd1;
            state   <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          ra    <= ram_rdata;
          idx_j <= j_next;
          state <= S_SWP;
        end
        S_SWP: begin
          rb    <= ram_rdata;
          state <= S_WRJ;
        end
        S_WRJ: state <= S_RDO;
        S_RDO: state <= S_OUT;
        S_OUT: begin
          if (discarding) begin
            state <= S_DISC;
          end else begin
            word <= {word[23:0], ram_rdata};
            if (kind == KIND_BYTE) begin
              budget <= spend[32:31] == 2'b10 ? BudgetFloor : spend[31:0];
              ov <= 1'b1; oval <= {24'd0, ram_rdata}; odue <= due;
              state <= S_IDLE;
            end else if (byte_cnt != 2'd3) begin
              byte_cnt <= byte_cnt + 2'd1;
              idx_i    <= idx_i + 8'd1;
              state    <= S_RDA;
            end else begin
              budget <= spend[32:31] == 2'b10 ? BudgetFloor : spend[31:0];
              byte_cnt <= 2'd0;
              if (kind == KIND_WORD) begin
                ov <= 1'b1; oval <= {word[23:0], ram_rdata}; odue <= due;
                state <= S_IDLE;
              end else if (mreq.start) begin
                state <= S_MOD1;
              end else begin
                // rejected: check budget after spend, try another word
                due   <= due || spend[32] || spend[31:0] == 32'd0;
                idx_i <= idx_i + 8'd1;
                state <= S_RDA;
              end
            end
          end
        end
        S_MOD1: begin
          if (mrsp.done) begin
            ov <= 1'b1; oval <= mrsp.rem; odue <= due;
            state <= S_IDLE;
          end
        end
        S_EMIT: state <= S_IDLE;
        S_SEED: begin
          // key byte is registered; start mixing from i-1+1 = i
          state <= S_KRDA;
        end
        S_KRDA: state <= S_KRDB;
        S_KRDB: begin
          ra    <= ram_rdata;
          idx_j <= j_next + seed_rdata;
          state <= S_KSWP;
        end
        S_KSWP: state <= S_KWRJ;
        S_KWRJ: begin
          key_pos <= (KeyLenW'(key_pos) + 1'b1 == key_len) ? '0 : key_pos + 1'b1;
          mix_cnt <= mix_cnt + 9'd1;
          if (mix_cnt == 9'd255) begin
            idx_j     <= idx_i;
            disc_left <= discard_count;
            seed_len  <= '0;
            state     <= S_DISC;
          end else begin
            idx_i <= idx_i + 8'd1;
            state <= S_SEED;
          end
        end
        S_DISC: begin
          discarding <= 1'b1;
          if (disc_left == 12'd0) begin
            budget <= {8'd0, reseed_budget};
            state  <= S_IDLE;
          end else begin
            disc_left <= disc_left - 12'd1;
            idx_i     <= idx_i + 8'd1;
            state     <= S_RDA;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // idle handshake only with output slot free
  assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while result pending");

  // result appears only on return to idle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> state == S_IDLE)
    else $error("result raised outside idle");

  // non-negative budget never above 2^24-1, the largest configured load
  assert property (@(posedge clk) disable iff (rst)
    !budget[31] |-> budget <= 32'd16777215)
    else $error("budget out of range");

  // modulo unit only started when not busy
  assert property (@(posedge clk) disable iff (rst)
    mreq.start |-> !mrsp.busy)
    else $error("modulo unit restarted while busy");

endmodule

// ===== rtl/core/rc4_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rc4_mod_unit: bit-serial restoring remainder
// Computes dividend mod divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rc4_mod_unit
  import rc4_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic [32:0] dvd;
  logic [31:0] dsr;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;

  logic [33:0] trial;
  logic [33:0] shifted;

  always_comb begin
    shifted = {rem, dvd[32]};
    trial   = shifted - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && cnt == 6'd32;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        // shift in one dividend bit, subtract where it fits
        dvd <= {dvd[31:0], 1'b0};
        if (!trial[33]) rem <= trial[32:0];
        else            rem <= shifted[32:0];
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem[31:0];

endmodule
